// ----- rtl/core/buddy_page_allocator_macros.svh -----
// Assertion macros for the buddy page allocator.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define BPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BPA_ASSERT_NEVER(label, prop, msg) \
  `BPA_ASSERT(label, !(prop), msg)
`else
`define BPA_ASSERT(label, prop, msg)
`define BPA_ASSERT_NEVER(label, prop, msg)
`endif
`endif

// ----- rtl/core/bpa_pkg.sv -----
// Shared types, codes and helper functions of the buddy page allocator.
// No dependencies; imported by the allocator top, mark store, address unit, checker and testbench.
`default_nettype none
package bpa_pkg;

  localparam int WORD_BITS = 64;
  localparam int BIT_IDX_W = 6;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_RESERVE = 2'd2,
    REQ_INIT    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_BLOCK = 2'd1,
    STAT_BAD_ARG  = 2'd2,
    STAT_NOT_FREE = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    PH_SCAN   = 6'b000001,
    PH_SPLIT  = 6'b000010,
    PH_FREE   = 6'b000100,
    PH_RFIND  = 6'b001000,
    PH_RSPLIT = 6'b010000,
    PH_INIT   = 6'b100000
  } phase_e;

  typedef logic [WORD_BITS-1:0] word_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [BIT_IDX_W-1:0] ffs(input word_t v);
    logic [BIT_IDX_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bpa_req_if.sv -----
// Request channel of the buddy page allocator: valid, ready and one request beat.
// Depends on nothing.
`default_nettype none
interface bpa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] page_number;
  logic [3:0]  block_order;

  modport source (output valid, output req_type, output page_number, output block_order,
                  input ready);
  modport sink   (input valid, input req_type, input page_number, input block_order,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/core/bpa_rsp_if.sv -----
// Response channel of the buddy page allocator: valid, ready and one result beat.
// Depends on nothing.
`default_nettype none
interface bpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] result_page;

  modport source (output valid, output status, output result_page, input ready);
  modport sink   (input valid, input status, input result_page, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/buddy_page_allocator.sv -----
// Top level of the buddy page allocator: sequencer, request decode and result register.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if, bpa_mark_ram, bpa_addr_unit and the macros.
//
//   channel   direction  handshake           beat
//   req_i     in         valid/ready         req_type, page_number, block_order
//   rsp_o     out        valid/ready         status, result_page
//   cfg       in         cfg_we_i only       cfg_wdata_i -> top-block count
//
// Every mark access is a read-modify-write of one 64-bit word through the shared
// address unit, with the address set in ST_RD and the write in ST_MOD. An allocate scans
// each order word by word from the requested order upward; the orders together hold
// about 2^(PAGE_BITS-5) words. Free, reserve and splitting do one access per order visited.
// After reset, and for every initialise request, a clearing pass writes all
// 2^(PAGE_BITS-5) words, one a cycle (2048 words at the default sizes); no request
// is taken during it. A finished result sits in the output register until taken.
`default_nettype none
`include "buddy_page_allocator_macros.svh"
module buddy_page_allocator #(
  parameter int ORDERS    = 11,
  parameter int PAGE_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bpa_req_if.sink    req_i,
  bpa_rsp_if.source  rsp_o,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i
);
  import bpa_pkg::*;

  localparam int TOP   = ORDERS - 1;
  localparam int LIM   = (TOP <= PAGE_BITS) ? TOP : PAGE_BITS;
  localparam int AVAIL = (TOP <= PAGE_BITS) ? (1 << ((TOP <= PAGE_BITS) ? PAGE_BITS - TOP : 0))
                                            : 0;
  localparam int OW    = $clog2(ORDERS);
  localparam int AW    = PAGE_BITS - 5;
  localparam int SW    = $clog2(PAGE_BITS + 2);

  typedef enum logic [4:0] {
    ST_CLR  = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_RD   = 5'b00100,
    ST_MOD  = 5'b01000,
    ST_RESP = 5'b10000
  } state_e;

  state_e   state_q, state_d;
  phase_e   phase_q, phase_d;
  logic [OW-1:0]        o_q, o_d, ord_q, ord_d;
  logic [PAGE_BITS-1:0] b_q, b_d, page_q, page_d;
  logic [BIT_IDX_W-1:0] bit_q, bit_d;
  logic [AW-1:0]        waddr_q, waddr_d, clr_q, clr_d;
  logic                 init_pend_q, init_pend_d;
  logic [6:0]           tbc_q, ninit_q, ninit_d;
  logic [1:0]           stat_q, stat_d;
  logic [15:0]          res_q, res_d;
  logic                 rsp_valid_q;
  logic [1:0]           rsp_status_q;
  logic [15:0]          rsp_page_q;

  // Shared address unit and mark store.
  logic [AW-1:0]        au_word;
  logic [BIT_IDX_W-1:0] au_bit;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  word_t                ram_wdata, rdata;

  bpa_addr_unit #(.PAGE_BITS(PAGE_BITS), .OW(OW)) u_addr (
    .order_i (o_q),
    .block_i (b_q),
    .word_o  (au_word),
    .bit_o   (au_bit)
  );

  bpa_mark_ram #(.AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (au_word),
    .rdata_o (rdata)
  );

  // Request decode terms.
  logic        req_acc;
  logic        ord_ok, aligned, page_in;
  logic [15:0] align_mask;
  logic [31:0] page32_in;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  always_comb begin
    page32_in  = 32'(req_i.page_number);
    ord_ok     = (32'(req_i.block_order) < ORDERS) && (32'(req_i.block_order) <= PAGE_BITS);
    align_mask = (16'd1 << req_i.block_order) - 16'd1;
    aligned    = (req_i.page_number & align_mask) == 16'd0;
    page_in    = (page32_in >> PAGE_BITS) == 32'd0;
  end

  // Scan window of the current order within the word just read.
  logic [SW-1:0]        pe;
  logic                 full_word, last_word, hit;
  word_t                mask, masked;
  logic [BIT_IDX_W-1:0] hit_bit;
  logic [PAGE_BITS-1:0] b_found, page_found;
  logic [OW-1:0]        om1;
  logic [PAGE_BITS:0]   n_blocks;

  always_comb begin
    pe        = SW'(PAGE_BITS) - SW'(o_q);
    full_word = pe >= SW'(BIT_IDX_W);
    mask      = full_word ? '1 : (((word_t'(1) << (7'd1 << pe[2:0])) - word_t'(1)) << bit_q);
    masked    = rdata & mask;
    hit       = |masked;
    hit_bit   = ffs(masked);
    b_found   = b_q + PAGE_BITS'(hit_bit - bit_q);
    page_found = b_found << o_q;
    n_blocks  = (PAGE_BITS + 1)'(1) << pe;
    last_word = !full_word || (({1'b0, b_q} + (PAGE_BITS + 1)'(WORD_BITS)) >= n_blocks);
    om1       = o_q - OW'(1);
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    o_d         = o_q;
    ord_d       = ord_q;
    b_d         = b_q;
    page_d      = page_q;
    bit_d       = bit_q;
    waddr_d     = waddr_q;
    clr_d       = clr_q;
    init_pend_d = init_pend_q;
    ninit_d     = ninit_q;
    stat_d      = stat_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = waddr_q;
    ram_wdata   = rdata;

    unique case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == '1) begin
          if (!init_pend_q) begin
            state_d = ST_IDLE;
          end else if (ninit_q == 7'd0) begin
            state_d = ST_RESP;
          end else begin
            o_d     = OW'(TOP);
            b_d     = '0;
            phase_d = PH_INIT;
            state_d = ST_RD;
          end
        end
      end

      ST_IDLE: begin
        if (req_acc) begin
          stat_d = STAT_OK;
          res_d  = '0;
          ord_d  = OW'(req_i.block_order);
          page_d = page32_in[PAGE_BITS-1:0];
          unique case (req_e'(req_i.req_type))
            REQ_ALLOC: begin
              if (!ord_ok) begin
                stat_d  = STAT_BAD_ARG;
                state_d = ST_RESP;
              end else begin
                o_d     = OW'(req_i.block_order);
                b_d     = '0;
                phase_d = PH_SCAN;
                state_d = ST_RD;
              end
            end
            REQ_FREE: begin
              if (!ord_ok || !aligned || !page_in) begin
                stat_d  = STAT_BAD_ARG;
                state_d = ST_RESP;
              end else begin
                o_d     = OW'(req_i.block_order);
                b_d     = page32_in[PAGE_BITS-1:0] >> req_i.block_order;
                phase_d = PH_FREE;
                state_d = ST_RD;
              end
            end
            REQ_RESERVE: begin
              if (!page_in) begin
                stat_d  = STAT_NOT_FREE;
                state_d = ST_RESP;
              end else begin
                o_d     = '0;
                b_d     = page32_in[PAGE_BITS-1:0];
                phase_d = PH_RFIND;
                state_d = ST_RD;
              end
            end
            REQ_INIT: begin
              clr_d       = '0;
              init_pend_d = 1'b1;
              ninit_d     = (32'(tbc_q) > AVAIL) ? 7'(AVAIL) : tbc_q;
              state_d     = ST_CLR;
            end
            default: ;
          endcase
        end
      end

      ST_RD: begin
        waddr_d = au_word;
        bit_d   = au_bit;
        state_d = ST_MOD;
      end

      ST_MOD: begin
        state_d = ST_RD;
        unique case (phase_q)
          PH_SCAN: begin
            if (hit) begin
              ram_we             = 1'b1;
              ram_wdata[hit_bit] = 1'b0;
              page_d             = page_found;
              res_d              = 16'(32'(page_found));
              if (o_q == ord_q) begin
                state_d = ST_RESP;
              end else begin
                o_d     = om1;
                b_d     = (page_found >> om1) | PAGE_BITS'(1);
                phase_d = PH_SPLIT;
              end
            end else if (!last_word) begin
              b_d = b_q + PAGE_BITS'(WORD_BITS);
            end else if (32'(o_q) < LIM) begin
              o_d = o_q + OW'(1);
              b_d = '0;
            end else begin
              stat_d  = STAT_NO_BLOCK;
              state_d = ST_RESP;
            end
          end
          PH_SPLIT: begin
            ram_we           = 1'b1;
            ram_wdata[bit_q] = 1'b1;
            if (o_q == ord_q) begin
              state_d = ST_RESP;
            end else begin
              o_d = om1;
              b_d = (page_q >> om1) | PAGE_BITS'(1);
            end
          end
          PH_FREE: begin
            ram_we = 1'b1;
            // A free buddy merges: both halves clear, the parent is tried next.
            if ((32'(o_q) < TOP) && (32'(o_q) < PAGE_BITS) &&
                rdata[bit_q ^ BIT_IDX_W'(1)]) begin
              ram_wdata[bit_q]                  = 1'b0;
              ram_wdata[bit_q ^ BIT_IDX_W'(1)] = 1'b0;
              o_d = o_q + OW'(1);
              b_d = b_q >> 1;
            end else begin
              ram_wdata[bit_q] = 1'b1;
              state_d          = ST_RESP;
            end
          end
          PH_RFIND: begin
            if (rdata[bit_q]) begin
              ram_we           = 1'b1;
              ram_wdata[bit_q] = 1'b0;
              if (o_q == '0) begin
                state_d = ST_RESP;
              end else begin
                o_d     = om1;
                b_d     = (page_q >> om1) ^ PAGE_BITS'(1);
                phase_d = PH_RSPLIT;
              end
            end else if (32'(o_q) < LIM) begin
              o_d = o_q + OW'(1);
              b_d = page_q >> (o_q + OW'(1));
            end else begin
              stat_d  = STAT_NOT_FREE;
              state_d = ST_RESP;
            end
          end
          PH_RSPLIT: begin
            ram_we           = 1'b1;
            ram_wdata[bit_q] = 1'b1;
            if (o_q == '0) begin
              state_d = ST_RESP;
            end else begin
              o_d = om1;
              b_d = (page_q >> om1) ^ PAGE_BITS'(1);
            end
          end
          PH_INIT: begin
            ram_we           = 1'b1;
            ram_wdata[bit_q] = 1'b1;
            if ((b_q + PAGE_BITS'(1)) == PAGE_BITS'(ninit_q)) begin
              state_d = ST_RESP;
            end else begin
              b_d = b_q + PAGE_BITS'(1);
            end
          end
          default: state_d = ST_RESP;
        endcase
      end

      ST_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          init_pend_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      init_pend_q <= 1'b0;
      tbc_q       <= 7'd64;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      init_pend_q <= init_pend_d;
      if (cfg_we_i) begin
        tbc_q <= cfg_wdata_i;
      end
      if (state_q == ST_RESP && (!rsp_valid_q || rsp_o.ready)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    o_q     <= o_d;
    ord_q   <= ord_d;
    b_q     <= b_d;
    page_q  <= page_d;
    bit_q   <= bit_d;
    waddr_q <= waddr_d;
    ninit_q <= ninit_d;
    stat_q  <= stat_d;
    res_q   <= res_d;
    if (state_q == ST_RESP && (!rsp_valid_q || rsp_o.ready)) begin
      rsp_status_q <= stat_q;
      rsp_page_q   <= res_q;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.result_page = rsp_page_q;

  `BPA_ASSERT(a_state_onehot, $onehot(state_q), "sequencer state lost its one-hot code")
  `BPA_ASSERT(a_acc_leaves_idle, req_acc |=> (state_q != ST_IDLE), "request beat did not start work")
  `BPA_ASSERT_NEVER(a_no_req_in_clear, (state_q == ST_CLR) && req_i.ready, "request taken during clearing")
  `BPA_ASSERT(a_scan_bound, ((state_q == ST_RD) && (phase_q == PH_SCAN)) |-> (32'(o_q) <= LIM),
              "scan went past the top order")
endmodule
`default_nettype wire

// ----- rtl/core/bpa_mark_ram.sv -----
// Word-wide store of the free marks, one write and one registered read per cycle.
// Depends on bpa_pkg.
`default_nettype none
module bpa_mark_ram #(
  parameter int AW = 11
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [AW-1:0]      waddr_i,
  input  wire bpa_pkg::word_t     wdata_i,
  input  wire logic [AW-1:0]      raddr_i,
  output bpa_pkg::word_t          rdata_o
);
  import bpa_pkg::*;

  word_t mem [2**AW];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ----- rtl/core/bpa_addr_unit.sv -----
// Shared mark address unit: maps an order and block index to word and bit.
// Depends on bpa_pkg.
`default_nettype none
module bpa_addr_unit #(
  parameter int PAGE_BITS = 16,
  parameter int OW        = 4
) (
  input  wire logic [OW-1:0]                 order_i,
  input  wire logic [PAGE_BITS-1:0]          block_i,
  output logic [PAGE_BITS-5-1:0]             word_o,
  output logic [bpa_pkg::BIT_IDX_W-1:0]      bit_o
);
  import bpa_pkg::*;

  localparam int MB = PAGE_BITS + 1;
  localparam int SW = $clog2(PAGE_BITS + 2);

  logic [SW-1:0] shamt;
  logic [MB-1:0] base;
  logic [MB-1:0] pos;

  // The marks of order o start where the smaller orders' marks end, so the
  // base is all ones from bit PAGE_BITS+1-o upward.
  always_comb begin
    shamt = SW'(PAGE_BITS + 1) - SW'(order_i);
    base  = {MB{1'b1}} << shamt;
    pos   = base + {1'b0, block_i};
  end

  assign word_o = pos[MB-1:BIT_IDX_W];
  assign bit_o  = pos[BIT_IDX_W-1:0];
endmodule
`default_nettype wire

// ----- verif/bpa_alloc_checker.sv -----
// Checker for the buddy page allocator: it predicts every response beat and compares it.
// Depends on bpa_pkg, bpa_req_if and bpa_rsp_if; instantiated beside the block by testbench.
`default_nettype none
module bpa_alloc_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  bpa_req_if              req,
  bpa_rsp_if              rsp,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  output int              fail_count,
  output int              pending_count
);
  import bpa_pkg::*;

  localparam int NUM_ORDERS = 11;
  localparam int TOP_ORD    = NUM_ORDERS - 1;
  localparam int PG_BITS    = 16;
  localparam int MARK_TOTAL = 1 << (PG_BITS + 1);

  typedef struct packed {
    status_e     status;
    logic [15:0] page;
  } alloc_rsp_t;

  bit         free_mark [MARK_TOTAL];
  int         free_per_order [NUM_ORDERS];
  logic [6:0] init_blocks;
  alloc_rsp_t awaited_rsp [$];

  function automatic int order_first(int o);
    return MARK_TOTAL - (1 << (PG_BITS + 1 - o));
  endfunction

  function automatic bit is_free(int o, int b);
    if (b < 0 || b >= (1 << (PG_BITS - o))) return 1'b0;
    return free_mark[order_first(o) + b];
  endfunction

  task automatic set_free(int o, int b, bit v);
    int pos;
    if (b < 0 || b >= (1 << (PG_BITS - o))) return;
    pos = order_first(o) + b;
    if (free_mark[pos] != v) begin
      free_mark[pos] = v;
      free_per_order[o] += v ? 1 : -1;
    end
  endtask

  task automatic clear_marks();
    foreach (free_mark[i]) free_mark[i] = 1'b0;
    foreach (free_per_order[i]) free_per_order[i] = 0;
  endtask

  // Works out the response to one request and updates the free marks.
  task automatic allocate_step(input req_e kind, input logic [15:0] pg, input logic [3:0] ord,
                               output alloc_rsp_t r);
    int o, b, k, n;
    bit got;
    r.status = STAT_OK;
    r.page   = '0;
    got      = 1'b0;
    b        = 0;
    case (kind)
      REQ_ALLOC: begin
        if (ord >= NUM_ORDERS) begin
          r.status = STAT_BAD_ARG;
        end else begin
          for (o = ord; o <= TOP_ORD && !got; o++) begin
            if (free_per_order[o] > 0) begin
              for (b = 0; b < (1 << (PG_BITS - o)); b++) begin
                if (is_free(o, b)) break;
              end
              got = 1'b1;
              break;
            end
          end
          if (!got) begin
            r.status = STAT_NO_BLOCK;
          end else begin
            set_free(o, b, 1'b0);
            for (k = o; k > ord; k--) begin
              b = b << 1;
              set_free(k - 1, b + 1, 1'b1);
            end
            r.page = 16'(b << ord);
          end
        end
      end
      REQ_FREE: begin
        if (ord >= NUM_ORDERS || (int'(pg) & ((1 << ord) - 1)) != 0) begin
          r.status = STAT_BAD_ARG;
        end else begin
          o = ord;
          b = int'(pg) >> ord;
          set_free(o, b, 1'b1);
          while (o < TOP_ORD && is_free(o, b ^ 1)) begin
            set_free(o, b, 1'b0);
            set_free(o, b ^ 1, 1'b0);
            b = b >> 1;
            o++;
            set_free(o, b, 1'b1);
          end
        end
      end
      REQ_RESERVE: begin
        for (o = 0; o <= TOP_ORD; o++) begin
          if (is_free(o, int'(pg) >> o)) begin
            got = 1'b1;
            break;
          end
        end
        if (!got) begin
          r.status = STAT_NOT_FREE;
        end else begin
          set_free(o, int'(pg) >> o, 1'b0);
          for (k = o; k > 0; k--) set_free(k - 1, (int'(pg) >> (k - 1)) ^ 1, 1'b1);
        end
      end
      default: begin
        clear_marks();
        n = init_blocks;
        if (n > (1 << (PG_BITS - TOP_ORD))) n = 1 << (PG_BITS - TOP_ORD);
        for (k = 0; k < n; k++) set_free(TOP_ORD, k, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_rsp_t want, seen;
    if (!rst_ni) begin
      clear_marks();
      init_blocks = 7'd64;
      awaited_rsp.delete();
      fail_count  = 0;
    end else begin
      if (cfg_we_i) init_blocks = cfg_wdata_i;
      if (req.valid && req.ready) begin
        allocate_step(req_e'(req.req_type), req.page_number, req.block_order, want);
        awaited_rsp.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        seen.status = status_e'(rsp.status);
        seen.page   = rsp.result_page;
        if (awaited_rsp.size() == 0) begin
          $error("response beat with nothing awaited: status %0d page %0h",
                 seen.status, seen.page);
          fail_count++;
        end else begin
          want = awaited_rsp.pop_front();
          if (seen.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, seen.status);
            fail_count++;
          end
          if (seen.page != want.page) begin
            $error("result_page: expected %0h, got %0h", want.page, seen.page);
            fail_count++;
          end
        end
      end
    end
    pending_count = awaited_rsp.size();
  end

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Top of the buddy page allocator testbench: clock, reset, request stimulus and verdict.
// Depends on bpa_pkg, the two channel interfaces, buddy_page_allocator and bpa_alloc_checker.
`default_nettype none
module testbench;
  import bpa_pkg::*;

  // The slowest requests are initialise (a clearing pass over the whole mark store) and
  // an allocate that scans empty low orders; the limit allows several times their length
  // for every beat.
  localparam int CYCLE_LIMIT = 40000000;
  localparam int RANDOM_BEATS = 1400;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = '0;
  int         fail_count, pending_count;
  int         cycle_count = 0;
  bit         calm = 1'b0;

  bpa_req_if req_ch ();
  bpa_rsp_if rsp_ch ();

  buddy_page_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  bpa_alloc_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.req_type    = '0;
    req_ch.page_number = '0;
    req_ch.block_order = '0;
    rsp_ch.ready       = 1'b0;
  end

  // The receiver stalls in about a fifth of the cycles, except during the calm stretch.
  always @(posedge clk_i) begin
    rsp_ch.ready <= calm || ($urandom_range(99) >= 21);
  end

  // A run that hangs is cut off here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Drives one request beat and holds it until the block takes it. Valid stays high
  // afterwards unless an idle gap follows, so back-to-back beats never lower and raise it within one step.
  task automatic send_request(req_e kind, logic [15:0] pg, logic [3:0] ord);
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.page_number <= pg;
    req_ch.block_order <= ord;
    do @(posedge clk_i); while (!req_ch.ready);
    // Random idle cycles between beats outside the calm stretch, so that gaps land on every phase of the work.
    if (!calm && $urandom_range(99) < 21) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Settles the block, then writes the top-block count and applies it by an initialise.
  // Every request has a response, so once none is outstanding the block is idle.
  task automatic set_top_blocks(logic [6:0] count);
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    send_request(REQ_INIT, 16'($urandom()), 4'($urandom()));
  endtask

  // Mostly well-formed requests with random content, with some broken ones mixed in.
  task automatic random_request();
    int         pick;
    logic [3:0] ord;
    logic [15:0] pg;
    pick = $urandom_range(99);
    ord  = ($urandom_range(99) < 90) ? 4'($urandom_range(0, 10)) : 4'($urandom());
    pg   = 16'($urandom());
    if (pick < 40) begin
      send_request(REQ_ALLOC, pg, ord);
    end else if (pick < 75) begin
      if ($urandom_range(99) < 85 && ord < 11) pg = pg & ~16'((1 << ord) - 1);
      send_request(REQ_FREE, pg, ord);
    end else if (pick < 98) begin
      send_request(REQ_RESERVE, pg, ord);
    end else begin
      send_request(REQ_INIT, pg, ord);
    end
  endtask

  initial begin
    logic [6:0] count;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Nothing is free after reset.
    send_request(REQ_ALLOC,   16'h0000, 4'd0);
    send_request(REQ_RESERVE, 16'h0000, 4'd0);
    send_request(REQ_ALLOC,   16'hFFFF, 4'd11);
    send_request(REQ_FREE,    16'h0000, 4'd15);
    send_request(REQ_FREE,    16'h0001, 4'd1);
    send_request(REQ_INIT,    16'h0000, 4'd0);
    // Default count: the whole page space is free in top-order blocks.
    send_request(REQ_ALLOC,   16'h0000, 4'd10);
    send_request(REQ_ALLOC,   16'h0000, 4'd0);
    send_request(REQ_ALLOC,   16'h0000, 4'd0);
    send_request(REQ_RESERVE, 16'hFFFF, 4'd0);
    send_request(REQ_RESERVE, 16'h0001, 4'd0);
    send_request(REQ_FREE,    16'h0000, 4'd0);
    send_request(REQ_FREE,    16'hFFC0, 4'd6);
    // A free of a block that is already free is accepted and merges as usual.
    send_request(REQ_FREE,    16'hFFC0, 4'd6);
    send_request(REQ_ALLOC,   16'h0000, 4'd4);
    send_request(REQ_FREE,    16'hFC00, 4'd10);

    // Extremes of the register: none, an oversized count that is clamped, then one.
    set_top_blocks(7'd0);
    send_request(REQ_ALLOC,   16'h0000, 4'd0);
    set_top_blocks(7'd127);
    send_request(REQ_RESERVE, 16'hFFFF, 4'd0);
    set_top_blocks(7'd1);
    send_request(REQ_ALLOC,   16'h0000, 4'd10);
    send_request(REQ_ALLOC,   16'h0000, 4'd9);
    send_request(REQ_RESERVE, 16'h0400, 4'd0);

    // Random part, in phases with a fresh register setting each; one phase has no idling.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 200 == 0) begin
        case ($urandom_range(4))
          0:       count = 7'd0;
          1:       count = 7'd1;
          2:       count = 7'd127;
          3:       count = 7'd64;
          default: count = 7'($urandom_range(2, 70));
        endcase
        calm = (i == 600);
        set_top_blocks(count);
      end
      random_request();
    end
    calm = 1'b0;

    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/bpa_pkg.sv
rtl/core/bpa_req_if.sv
rtl/core/bpa_rsp_if.sv
rtl/core/bpa_mark_ram.sv
rtl/core/bpa_addr_unit.sv
rtl/core/buddy_page_allocator.sv
verif/bpa_alloc_checker.sv
verif/testbench.sv
